// File: design/owbm_pkg.sv
// Package with the shared types and constants of the 1-Wire bus master.
`timescale 1ns / 1ps

package owbm_pkg;

   // Field widths
   localparam int MODE_BITS      = 2;
   localparam int BYTE_BITS      = 8;
   localparam int STATUS_BITS    = 2;
   localparam int REG_BITS       = 10;
   localparam int CSR_INDEX_BITS = 3;
   localparam int BIT_INDEX_BITS = 3;
   localparam int LOW_COUNT_BITS = 2;

   // Command queue between the front and the engine
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Request mode codes
   localparam logic [MODE_BITS-1:0] MODE_TICK  = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_RESET = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_WRITE = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_READ  = 2'd3;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RESET_LOW     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRESENCE      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECOVERY      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLOT_SHORT    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLOT_LONG     = 3'd4;

   // Register reset values
   localparam logic [REG_BITS-1:0] RESET_LOW_DEFAULT  = 10'd500;
   localparam logic [REG_BITS-1:0] PRESENCE_DEFAULT   = 10'd75;
   localparam logic [REG_BITS-1:0] RECOVERY_DEFAULT   = 10'd500;
   localparam logic [REG_BITS-1:0] SLOT_SHORT_DEFAULT = 10'd7;
   localparam logic [REG_BITS-1:0] SLOT_LONG_DEFAULT  = 10'd70;

   // Presence status codes
   localparam logic [STATUS_BITS-1:0] STATUS_PRESENCE = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NO_DEV   = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_SHORTED  = 2'd2;

   // Phases inside an operation
   localparam logic [1:0] PH_LOW  = 2'd0;
   localparam logic [1:0] PH_WAIT = 2'd1;
   localparam logic [1:0] PH_LAST = 2'd2;

   localparam logic [BIT_INDEX_BITS-1:0] LAST_BIT = 3'd7;

   // Operation in progress in the engine
   typedef enum logic [1:0] {
      OP_IDLE,
      OP_RESET,
      OP_WRITE,
      OP_READ
   } op_kind_type;

   // Command class decided by the front
   typedef enum logic [2:0] {
      CMD_TICK,
      CMD_RESET,
      CMD_RESET_NODEV,
      CMD_WRITE,
      CMD_READ
   } cmd_type;

   // One classified tick as it travels through the queue
   typedef struct packed {
      cmd_type               cmd;
      logic [BYTE_BITS-1:0]  tx_byte;
      logic                  line_high;
   } item_type;

endpackage

// File: design/owbm_if.sv
// Channel interfaces of the 1-Wire bus master: request, response and register write.
`timescale 1ns / 1ps

interface owbm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] tx_byte;
   logic       line_in;

   modport source (output valid, output mode, output tx_byte, output line_in, input ready);
   modport sink   (input valid, input mode, input tx_byte, input line_in, output ready);
endinterface

interface owbm_rsp_if;
   logic       valid;
   logic       ready;
   logic       drive_low;
   logic       busy_res;
   logic       done_res;
   logic [1:0] reset_status;
   logic [7:0] rx_byte;

   modport source (output valid, output drive_low, output busy_res, output done_res,
                   output reset_status, output rx_byte, input ready);
   modport sink   (input valid, input drive_low, input busy_res, input done_res,
                   input reset_status, input rx_byte, output ready);
endinterface

interface owbm_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [9:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/owbm_front.sv
// Front end: accepts request transactions and classifies each tick's command.
`timescale 1ns / 1ps

module owbm_front
   import owbm_pkg::*;
(
   owbm_req_if.sink  req_if,
   input  logic      push_ready,
   output logic      push_valid,
   output item_type  push_item
);

   // Pass the handshake through to the queue
   assign push_valid = req_if.valid;
   assign req_if.ready = push_ready;

   // Classify the mode; a reset on a low bus ends at once with no device
   always_comb begin
      push_item.tx_byte   = req_if.tx_byte;
      push_item.line_high = req_if.line_in;
      case (req_if.mode)
         MODE_RESET: begin
            push_item.cmd = req_if.line_in ? CMD_RESET : CMD_RESET_NODEV;
         end
         MODE_WRITE: begin
            push_item.cmd = CMD_WRITE;
         end
         MODE_READ: begin
            push_item.cmd = CMD_READ;
         end
         default: begin
            push_item.cmd = CMD_TICK;
         end
      endcase
   end

endmodule

// File: design/owbm_queue.sv
// Short queue of classified ticks between the front and the engine.
`timescale 1ns / 1ps

module owbm_queue
   import owbm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  item_type push_item,
   output logic     push_ready,
   output logic     pop_valid,
   output item_type pop_item,
   input  logic     pop
);

   item_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   assign push_ready = (count_ff != QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry; payload needs no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: design/owbm_engine.sv
// Back end: bus timing engine, register file and response output register.
`timescale 1ns / 1ps

module owbm_engine
   import owbm_pkg::*;
#(
   parameter int TIMER_BITS = 10
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   input  item_type  pop_item,
   output logic      pop,
   owbm_csr_if.sink  csr_if,
   owbm_rsp_if.source rsp_if
);

   // Configuration registers
   logic [REG_BITS-1:0] reset_low_ff, presence_ff, recovery_ff, slot_short_ff, slot_long_ff;

   // Engine state
   op_kind_type               kind_ff, kind_in;
   logic [1:0]                phase_ff, phase_in;
   logic [TIMER_BITS-1:0]     timer_ff, timer_in;
   logic [BIT_INDEX_BITS-1:0] bit_ff, bit_in;
   logic [BYTE_BITS-1:0]      shift_ff, shift_in;
   logic [LOW_COUNT_BITS-1:0] low_cnt_ff, low_cnt_in;
   logic [STATUS_BITS-1:0]    status_ff, status_in;
   logic [BYTE_BITS-1:0]      received_ff, received_in;
   logic                      done;

   // Response output register
   logic                      rsp_valid_ff;
   logic                      drive_ff, busy_ff, done_ff;
   logic [STATUS_BITS-1:0]    status_out_ff;
   logic [BYTE_BITS-1:0]      rx_out_ff;

   // Count of a phase: duration less one, zero treated as one
   function automatic logic [TIMER_BITS-1:0] load_count(input logic [REG_BITS-1:0] duration);
      logic [REG_BITS-1:0] less_one;
      less_one = (duration != '0) ? duration - 1'b1 : '0;
      return TIMER_BITS'(less_one);
   endfunction

   // Take the next tick when the output register is free or being drained
   assign pop = pop_valid && (!rsp_valid_ff || rsp_if.ready);

   // Register writes, always accepted
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_low_ff  <= RESET_LOW_DEFAULT;
         presence_ff   <= PRESENCE_DEFAULT;
         recovery_ff   <= RECOVERY_DEFAULT;
         slot_short_ff <= SLOT_SHORT_DEFAULT;
         slot_long_ff  <= SLOT_LONG_DEFAULT;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_RESET_LOW:  reset_low_ff  <= csr_if.data;
            CSR_PRESENCE:   presence_ff   <= csr_if.data;
            CSR_RECOVERY:   recovery_ff   <= csr_if.data;
            CSR_SLOT_SHORT: slot_short_ff <= csr_if.data;
            CSR_SLOT_LONG:  slot_long_ff  <= csr_if.data;
            default: ;
         endcase
      end
   end

   // Next state of the bus sequencer for one tick
   always_comb begin
      kind_in     = kind_ff;
      phase_in    = phase_ff;
      timer_in    = timer_ff;
      bit_in      = bit_ff;
      shift_in    = shift_ff;
      low_cnt_in  = low_cnt_ff;
      status_in   = status_ff;
      received_in = received_ff;
      done        = 1'b0;
      if (pop) begin
         case (kind_ff)
            OP_IDLE: begin
               case (pop_item.cmd)
                  CMD_RESET_NODEV: begin
                     status_in = STATUS_NO_DEV;
                     done      = 1'b1;
                  end
                  CMD_RESET: begin
                     kind_in    = OP_RESET;
                     phase_in   = PH_LOW;
                     low_cnt_in = '0;
                     timer_in   = load_count(reset_low_ff);
                  end
                  CMD_WRITE: begin
                     kind_in  = OP_WRITE;
                     shift_in = pop_item.tx_byte;
                     bit_in   = '0;
                     phase_in = PH_LOW;
                     timer_in = load_count(pop_item.tx_byte[0] ? slot_short_ff : slot_long_ff);
                  end
                  CMD_READ: begin
                     kind_in  = OP_READ;
                     shift_in = '0;
                     bit_in   = '0;
                     phase_in = PH_LOW;
                     timer_in = load_count(slot_short_ff);
                  end
                  default: ;
               endcase
            end
            default: begin
               if (timer_ff != '0) begin
                  timer_in = timer_ff - TIMER_BITS'(1);
               end else begin
                  case (kind_ff)
                     // Reset: release, first sample, second sample and finish
                     OP_RESET: begin
                        if (phase_ff == PH_LOW) begin
                           phase_in = PH_WAIT;
                           timer_in = load_count(presence_ff);
                        end else begin
                           if (!pop_item.line_high) begin
                              low_cnt_in = low_cnt_ff + 1'b1;
                           end
                           if (phase_ff == PH_WAIT) begin
                              phase_in = PH_LAST;
                              timer_in = load_count(recovery_ff);
                           end else begin
                              case (low_cnt_in)
                                 2'd0:    status_in = STATUS_NO_DEV;
                                 2'd1:    status_in = STATUS_PRESENCE;
                                 default: status_in = STATUS_SHORTED;
                              endcase
                              kind_in  = OP_IDLE;
                              phase_in = PH_LOW;
                              done     = 1'b1;
                           end
                        end
                     end
                     // Write: low part, released part, next bit
                     OP_WRITE: begin
                        if (phase_ff == PH_LOW) begin
                           phase_in = PH_WAIT;
                           timer_in = load_count(shift_ff[0] ? slot_long_ff : slot_short_ff);
                        end else begin
                           shift_in = shift_ff >> 1;
                           if (bit_ff == LAST_BIT) begin
                              kind_in  = OP_IDLE;
                              phase_in = PH_LOW;
                              bit_in   = '0;
                              done     = 1'b1;
                           end else begin
                              bit_in   = bit_ff + 1'b1;
                              phase_in = PH_LOW;
                              timer_in = load_count(shift_ff[1] ? slot_short_ff : slot_long_ff);
                           end
                        end
                     end
                     // Read: low part, sample after release, recovery
                     default: begin
                        if (phase_ff == PH_LOW) begin
                           phase_in = PH_WAIT;
                           timer_in = load_count(slot_short_ff);
                        end else if (phase_ff == PH_WAIT) begin
                           shift_in = {pop_item.line_high, shift_ff[BYTE_BITS-1:1]};
                           phase_in = PH_LAST;
                           timer_in = load_count(slot_long_ff);
                        end else if (bit_ff == LAST_BIT) begin
                           received_in = shift_ff;
                           kind_in     = OP_IDLE;
                           phase_in    = PH_LOW;
                           bit_in      = '0;
                           done        = 1'b1;
                        end else begin
                           bit_in   = bit_ff + 1'b1;
                           phase_in = PH_LOW;
                           timer_in = load_count(slot_short_ff);
                        end
                     end
                  endcase
               end
            end
         endcase
      end
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff     <= OP_IDLE;
         phase_ff    <= PH_LOW;
         timer_ff    <= '0;
         bit_ff      <= '0;
         shift_ff    <= '0;
         low_cnt_ff  <= '0;
         status_ff   <= STATUS_NO_DEV;
         received_ff <= '0;
      end else begin
         kind_ff     <= kind_in;
         phase_ff    <= phase_in;
         timer_ff    <= timer_in;
         bit_ff      <= bit_in;
         shift_ff    <= shift_in;
         low_cnt_ff  <= low_cnt_in;
         status_ff   <= status_in;
         received_ff <= received_in;
      end
   end

   // Output register: fill on each tick taken, drop when the sink takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         drive_ff      <= (kind_in != OP_IDLE) && (phase_in == PH_LOW);
         busy_ff       <= (kind_in != OP_IDLE);
         done_ff       <= done;
         status_out_ff <= status_in;
         rx_out_ff     <= received_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.drive_low    = drive_ff;
   assign rsp_if.busy_res     = busy_ff;
   assign rsp_if.done_res     = done_ff;
   assign rsp_if.reset_status = status_out_ff;
   assign rsp_if.rx_byte      = rx_out_ff;

   // Idle engine has no phase or timer left over
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      kind_ff == OP_IDLE |-> phase_ff == PH_LOW && timer_ff == '0)
      else $error("idle engine holds a phase or a running timer");

   // Bus is only driven during an operation
   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && drive_ff |-> busy_ff)
      else $error("bus driven while not busy");

   // A finishing tick reports idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> !busy_ff)
      else $error("done reported while still busy");

   // A write taken while idle starts a write
   a_write_start: assert property (@(posedge clock) disable iff (reset)
      pop && kind_ff == OP_IDLE && pop_item.cmd == CMD_WRITE |=> kind_ff == OP_WRITE)
      else $error("write command did not start a write");

endmodule

// File: design/onewire_bus_master.sv
// Top level of the 1-Wire bus master: front, command queue and timing engine.
//
// Usage: one request transaction on req_if is one microsecond tick. It carries
// the sampled bus level (line_in) and a mode: tick only, start reset, start byte
// write (tx_byte, LSB first) or start byte read. A command is taken only when
// no operation runs; otherwise it counts as a plain tick.
// Every tick gives exactly one response transaction on rsp_if: drive_low for
// the pin, busy_res, a done_res pulse, the last reset status and the last byte
// read. The user must write registers on csr_if (index 0..4) only while the
// master is idle; the block itself does not enforce this. A tick accepted on
// req_if is stored in the queue, then taken by the engine into the output
// register, from which the receiver takes it. Throughput: one tick per cycle
// while the receiver takes each response.
// When the receiver stalls, the output register holds its response, the queue
// keeps accepting until its two entries are full, then req_if.ready drops.
// Reset clears the queue, the engine and the registers to their defaults;
// the status reads as no device and the received byte as zero.
`timescale 1ns / 1ps

module onewire_bus_master
   import owbm_pkg::*;
#(
   parameter int TIMER_BITS = 10
) (
   input  logic       clock,
   input  logic       reset,
   owbm_req_if.sink   req_if,
   owbm_rsp_if.source rsp_if,
   owbm_csr_if.sink   csr_if
);

   logic     push_valid;
   logic     push_ready;
   item_type push_item;
   logic     pop_valid;
   item_type pop_item;
   logic     pop;

   // Accept and classify
   owbm_front u_front (
      .req_if     (req_if),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   // Decouple front and engine
   owbm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop        (pop)
   );

   // Run bus timing
   owbm_engine #(
      .TIMER_BITS (TIMER_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop       (pop),
      .csr_if    (csr_if),
      .rsp_if    (rsp_if)
   );

endmodule
